/* hw/rtl/txcw_pkg.sv */
`default_nettype none
package txcw_pkg;

    // Screen geometry
    localparam int SCREEN_COLUMNS = 64;
    localparam int SCREEN_ROWS    = 16;

    localparam int COL_W      = $clog2(SCREEN_COLUMNS);
    localparam int ROW_W      = $clog2(SCREEN_ROWS);
    localparam int VW_W       = COL_W + 1;
    localparam int VH_W       = ROW_W + 1;
    localparam int ADDR_W     = 14;
    localparam int DATA_W     = 7;
    localparam int ROWS_W     = 5;
    localparam int OP_W       = 2;
    localparam int FUNC_W     = 2;
    localparam int CHAR_W     = 8;
    localparam int POS_W      = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 7;
    localparam int MAX_RESULTS = 8;
    localparam int BUF_IDX_W  = $clog2(MAX_RESULTS);
    localparam int BUF_CNT_W  = BUF_IDX_W + 1;
    localparam int TAB_W      = 3;
    localparam int TAB_STOP   = 4;

    localparam logic [ADDR_W-1:0] VRAM_BASE = 14'h3C00;
    localparam logic [DATA_W-1:0] BLANK     = 7'h20;
    localparam logic [DATA_W-1:0] LOWER_LO  = 7'd96;
    localparam logic [DATA_W-1:0] CASE_STEP = 7'd32;

    // Command codes
    localparam logic [FUNC_W-1:0] FUNC_PUT    = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_SET    = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_SCROLL = 2'd3;

    // Result codes
    localparam logic [OP_W-1:0] OP_WRITE  = 2'd0;
    localparam logic [OP_W-1:0] OP_SCROLL = 2'd1;
    localparam logic [OP_W-1:0] OP_FILL   = 2'd2;
    localparam logic [OP_W-1:0] OP_REPORT = 2'd3;

    // Control characters
    localparam logic [CHAR_W-1:0] CH_NUL = 8'd0;
    localparam logic [CHAR_W-1:0] CH_TAB = 8'd9;
    localparam logic [CHAR_W-1:0] CH_LF  = 8'd10;
    localparam logic [CHAR_W-1:0] CH_CR  = 8'd13;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_VIEW_LEFT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VIEW_TOP    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VIEW_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VIEW_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_AUTO_SCROLL = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LOWER_CASE  = 3'd5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GLYPH,
        ST_EXEC,
        ST_SETTLE,
        ST_SEND
    } state_t;

    typedef struct packed {
        logic capture;
        logic glyph;
        logic exec;
        logic settle;
        logic send_adv;
    } cmd_t;

    typedef struct packed {
        logic start_glyph;
        logic tab_pending;
        logic send_last;
    } status_t;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [ADDR_W-1:0] address;
        logic [DATA_W-1:0] data;
        logic [ROWS_W-1:0] rows;
    } entry_t;

    // Mask to 7 bits and fold lower case down unless lower case is fitted
    function automatic logic [DATA_W-1:0] fold(input logic [CHAR_W-1:0] c,
                                                input logic lc);
        logic [DATA_W-1:0] m;
        m = c[DATA_W-1:0];
        if (!lc && m >= LOWER_LO)
        begin
            m = m - CASE_STEP;
        end
        return m;
    endfunction

    // Video memory address of a viewport cell
    function automatic logic [ADDR_W-1:0] addr_of(input logic [COL_W-1:0] vl,
                                                   input logic [ROW_W-1:0] vt,
                                                   input logic [COL_W-1:0] x,
                                                   input logic [ROW_W-1:0] y);
        logic [ROW_W:0]    row;
        logic [ADDR_W+1:0] a;
        row = {1'b0, vt} + {1'b0, y};
        a = (ADDR_W+2)'(VRAM_BASE) + ((ADDR_W+2)'(row) << COL_W)
            + (ADDR_W+2)'(vl) + (ADDR_W+2)'(x);
        return a[ADDR_W-1:0];
    endfunction

endpackage
`default_nettype wire

/* hw/rtl/txcw_ctrl.sv */
`default_nettype none
module txcw_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  wire logic             out_ready,
    input  wire txcw_pkg::status_t status,
    output txcw_pkg::cmd_t        cmd
);
    import txcw_pkg::*;

    state_t state_reg;
    state_t state_next;

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = status.start_glyph ? ST_GLYPH : ST_EXEC;
                end
            end
            ST_GLYPH:  state_next = ST_SETTLE;
            ST_EXEC:   state_next = ST_SETTLE;
            ST_SETTLE: state_next = status.tab_pending ? ST_GLYPH : ST_SEND;
            ST_SEND:
            begin
                if (out_ready && status.send_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        in_ready     = 1'b0;
        out_valid    = 1'b0;
        cmd          = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            ST_GLYPH:  cmd.glyph  = 1'b1;
            ST_EXEC:   cmd.exec   = 1'b1;
            ST_SETTLE: cmd.settle = 1'b1;
            ST_SEND:
            begin
                out_valid    = 1'b1;
                cmd.send_adv = out_ready;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule
`default_nettype wire

/* hw/rtl/txcw_datapath.sv */
`default_nettype none
module txcw_datapath (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [txcw_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [txcw_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic [txcw_pkg::FUNC_W-1:0]       in_func,
    input  wire logic [txcw_pkg::CHAR_W-1:0]       in_char,
    input  wire logic                              in_raw,
    input  wire logic [txcw_pkg::POS_W-1:0]        in_pos_x,
    input  wire logic [txcw_pkg::POS_W-1:0]        in_pos_y,
    input  wire logic [txcw_pkg::POS_W-1:0]        in_scroll_rows,
    input  wire txcw_pkg::cmd_t                    cmd,
    output txcw_pkg::status_t                      status,
    output txcw_pkg::entry_t                       out_entry,
    output logic [txcw_pkg::COL_W-1:0]             cursor_x,
    output logic [txcw_pkg::ROW_W-1:0]             cursor_y
);
    import txcw_pkg::*;

    // Configuration registers
    logic [COL_W-1:0] view_left_reg;
    logic [ROW_W-1:0] view_top_reg;
    logic [VW_W-1:0]  view_width_reg;
    logic [VH_W-1:0]  view_height_reg;
    logic             auto_scroll_reg;
    logic             lower_case_reg;

    // Cursor and command state
    logic [COL_W-1:0]  col_reg,  col_next;
    logic [ROW_W-1:0]  line_reg, line_next;
    logic [FUNC_W-1:0] func_reg;
    logic [CHAR_W-1:0] char_reg;
    logic [POS_W-1:0]  pos_x_reg, pos_y_reg, scroll_rows_reg;
    logic [DATA_W-1:0] glyph_reg;
    logic [TAB_W-1:0]  tab_left_reg, tab_left_next;
    logic              pend_reg, pend_next;
    logic [BUF_CNT_W-1:0] cnt_reg;
    logic [BUF_IDX_W-1:0] rd_reg;
    entry_t            buf_reg [MAX_RESULTS];

    // Effective viewport
    logic [VW_W-1:0]  vw_raw, room_w, vw;
    logic [VH_W-1:0]  vh_raw, room_h, vh;
    logic [COL_W-1:0] vw_m1;
    logic [ROW_W-1:0] vh_m1;
    logic [ADDR_W-1:0] origin_addr;

    always_comb
    begin
        vw_raw = (view_width_reg == '0) ? VW_W'(1) : view_width_reg;
        room_w = VW_W'(SCREEN_COLUMNS) - {1'b0, view_left_reg};
        vw     = (vw_raw > room_w) ? room_w : vw_raw;
        vh_raw = (view_height_reg == '0) ? VH_W'(1) : view_height_reg;
        room_h = VH_W'(SCREEN_ROWS) - {1'b0, view_top_reg};
        vh     = (vh_raw > room_h) ? room_h : vh_raw;
        vw_m1  = COL_W'(vw - VW_W'(1));
        vh_m1  = ROW_W'(vh - VH_W'(1));
        origin_addr = addr_of(view_left_reg, view_top_reg, '0, '0);
    end

    // Clamp cursor into the viewport at the start of a command
    logic [COL_W-1:0] col_cl;
    logic [ROW_W-1:0] line_cl;
    logic             in_printable;

    always_comb
    begin
        col_cl  = (col_reg > vw_m1) ? vw_m1 : col_reg;
        line_cl = (line_reg > vh_m1) ? vh_m1 : line_reg;
        in_printable = (in_func == FUNC_PUT) && (in_char != CH_NUL)
                       && (in_char != CH_LF) && (in_char != CH_CR);
    end

    // Wrap and bottom handling after a glyph or a newline
    logic [VW_W-1:0] st_col;
    logic [VH_W-1:0] st_line;
    logic            st_scroll;

    always_comb
    begin
        if (cmd.glyph)
        begin
            st_col  = {1'b0, col_reg} + VW_W'(1);
            st_line = {1'b0, line_reg};
        end
        else
        begin
            st_col  = '0;
            st_line = {1'b0, line_reg} + VH_W'(1);
        end
        if (st_col >= vw)
        begin
            st_col  = '0;
            st_line = st_line + VH_W'(1);
        end
        st_scroll = 1'b0;
        if (st_line >= vh)
        begin
            if (auto_scroll_reg)
            begin
                st_line   = st_line - VH_W'(1);
                st_scroll = 1'b1;
            end
            else
            begin
                st_line = '0;
            end
        end
    end

    // Command step and result entry
    logic             wr_en;
    entry_t           wr_entry;
    logic [ROWS_W-1:0] sr_cap;

    always_comb
    begin
        col_next      = col_reg;
        line_next     = line_reg;
        tab_left_next = tab_left_reg;
        pend_next     = pend_reg;
        wr_en         = 1'b0;
        wr_entry      = '0;
        sr_cap = (scroll_rows_reg > POS_W'(vh)) ? ROWS_W'(vh)
                                                 : scroll_rows_reg[ROWS_W-1:0];
        if (cmd.glyph)
        begin
            wr_en            = 1'b1;
            wr_entry.op      = OP_WRITE;
            wr_entry.address = addr_of(view_left_reg, view_top_reg, col_reg, line_reg);
            wr_entry.data    = glyph_reg;
            col_next         = st_col[COL_W-1:0];
            line_next        = st_line[ROW_W-1:0];
            pend_next        = st_scroll;
            tab_left_next    = tab_left_reg - TAB_W'(1);
        end
        else if (cmd.exec)
        begin
            pend_next = 1'b0;
            case (func_reg)
                FUNC_PUT:
                begin
                    if (char_reg == CH_LF)
                    begin
                        col_next  = st_col[COL_W-1:0];
                        line_next = st_line[ROW_W-1:0];
                        pend_next = st_scroll;
                    end
                end
                FUNC_SET:
                begin
                    col_next  = (pos_x_reg >= POS_W'(vw)) ? vw_m1 : pos_x_reg[COL_W-1:0];
                    line_next = (pos_y_reg >= POS_W'(vh)) ? vh_m1 : pos_y_reg[ROW_W-1:0];
                end
                FUNC_CLEAR:
                begin
                    col_next         = '0;
                    line_next        = '0;
                    wr_en            = 1'b1;
                    wr_entry.op      = OP_FILL;
                    wr_entry.address = origin_addr;
                    wr_entry.data    = fold(char_reg, lower_case_reg);
                end
                FUNC_SCROLL:
                begin
                    if (scroll_rows_reg != '0)
                    begin
                        line_next = ({1'b0, line_reg} > sr_cap)
                                    ? ROW_W'({1'b0, line_reg} - sr_cap) : '0;
                        wr_en            = 1'b1;
                        wr_entry.op      = OP_SCROLL;
                        wr_entry.address = origin_addr;
                        wr_entry.data    = BLANK;
                        wr_entry.rows    = sr_cap;
                    end
                end
                default:
                begin
                    wr_en = 1'b0;
                end
            endcase
        end
        else if (cmd.settle)
        begin
            pend_next = 1'b0;
            if (pend_reg)
            begin
                wr_en            = 1'b1;
                wr_entry.op      = OP_SCROLL;
                wr_entry.address = origin_addr;
                wr_entry.data    = BLANK;
                wr_entry.rows    = ROWS_W'(1);
            end
            else if (tab_left_reg == '0 && cnt_reg == '0)
            begin
                wr_en            = 1'b1;
                wr_entry.op      = OP_REPORT;
                wr_entry.address = addr_of(view_left_reg, view_top_reg,
                                           col_reg, line_reg);
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            view_left_reg   <= '0;
            view_top_reg    <= '0;
            view_width_reg  <= VW_W'(SCREEN_COLUMNS);
            view_height_reg <= VH_W'(SCREEN_ROWS);
            auto_scroll_reg <= 1'b1;
            lower_case_reg  <= 1'b0;
            col_reg         <= '0;
            line_reg        <= '0;
            func_reg        <= FUNC_PUT;
            tab_left_reg    <= '0;
            pend_reg        <= 1'b0;
            cnt_reg         <= '0;
            rd_reg          <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_VIEW_LEFT:   view_left_reg   <= cfg_data[COL_W-1:0];
                    REG_VIEW_TOP:    view_top_reg    <= cfg_data[ROW_W-1:0];
                    REG_VIEW_WIDTH:  view_width_reg  <= cfg_data[VW_W-1:0];
                    REG_VIEW_HEIGHT: view_height_reg <= cfg_data[VH_W-1:0];
                    REG_AUTO_SCROLL: auto_scroll_reg <= cfg_data[0];
                    REG_LOWER_CASE:  lower_case_reg  <= cfg_data[0];
                    default:         view_left_reg   <= view_left_reg;
                endcase
            end
            if (cmd.capture)
            begin
                col_reg  <= col_cl;
                line_reg <= line_cl;
                func_reg <= in_func;
                pend_reg <= 1'b0;
                cnt_reg  <= '0;
                rd_reg   <= '0;
                if (in_func == FUNC_PUT && in_char == CH_TAB)
                begin
                    tab_left_reg <= TAB_W'(TAB_STOP) - {1'b0, col_cl[1:0]};
                end
                else if (in_printable)
                begin
                    tab_left_reg <= TAB_W'(1);
                end
                else
                begin
                    tab_left_reg <= '0;
                end
            end
            else
            begin
                col_reg      <= col_next;
                line_reg     <= line_next;
                tab_left_reg <= tab_left_next;
                pend_reg     <= pend_next;
                if (wr_en)
                begin
                    cnt_reg <= cnt_reg + BUF_CNT_W'(1);
                end
                if (cmd.send_adv)
                begin
                    rd_reg <= rd_reg + BUF_IDX_W'(1);
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            char_reg        <= in_char;
            pos_x_reg       <= in_pos_x;
            pos_y_reg       <= in_pos_y;
            scroll_rows_reg <= in_scroll_rows;
            if (in_char == CH_TAB)
            begin
                glyph_reg <= fold({1'b0, BLANK}, lower_case_reg);
            end
            else if (in_raw)
            begin
                glyph_reg <= in_char[DATA_W-1:0];
            end
            else
            begin
                glyph_reg <= fold(in_char, lower_case_reg);
            end
        end
        if (wr_en)
        begin
            buf_reg[cnt_reg[BUF_IDX_W-1:0]] <= wr_entry;
        end
    end

    // Status and result
    always_comb
    begin
        status.start_glyph = in_printable;
        status.tab_pending = (tab_left_reg != '0);
        status.send_last   = (({1'b0, rd_reg} + BUF_CNT_W'(1)) == cnt_reg);
        out_entry          = buf_reg[rd_reg];
        cursor_x           = col_reg;
        cursor_y           = line_reg;
    end

endmodule
`default_nettype wire

/* hw/rtl/text_console_cursor_writer_core.sv */
`default_nettype none
// Text console cursor writer for a 64x16 character screen in video memory at
// 0x3C00. Each request carries one command (put character, set cursor, clear
// viewport, scroll up) and yields 1 to 8 results: byte writes, viewport
// scrolls, viewport fills or one cursor report, each tagged with the cursor
// as it stands after the whole command and the final one marked by tlast.
// The block handles one request at a time and takes no new request until
// the last result of the previous one has left. For each glyph written (1
// for a plain character, 1 to 4 for a tab) the controller steps through a
// write state and a wrap/scroll state; every other command steps through an
// execute state and a settle state instead. The results then leave from an
// eight-entry result buffer, one per cycle while the sink is ready. The user
// must see that configuration is written only while no request is in
// progress; the block itself does not enforce this.
module text_console_cursor_writer_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Configuration write port
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [6:0]  cfg_data,
    // Command stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,  // char_code, pos_x, pos_y, scroll_rows
    input  wire logic [2:0]  s_axis_tuser,  // func, raw_byte
    // Result stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,  // address, data, rows, cursor_x,
                                            // cursor_y, zero fill
    output logic [1:0]       m_axis_tuser,  // op
    output logic             m_axis_tlast
);
    import txcw_pkg::*;

    cmd_t              cmd;
    status_t           status;
    entry_t            out_entry;
    logic [COL_W-1:0]  cursor_x;
    logic [ROW_W-1:0]  cursor_y;

    txcw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .status    (status),
        .cmd       (cmd)
    );

    txcw_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_func        (s_axis_tuser[1:0]),
        .in_char        (s_axis_tdata[7:0]),
        .in_raw         (s_axis_tuser[2]),
        .in_pos_x       (s_axis_tdata[15:8]),
        .in_pos_y       (s_axis_tdata[23:16]),
        .in_scroll_rows (s_axis_tdata[31:24]),
        .cmd            (cmd),
        .status         (status),
        .out_entry      (out_entry),
        .cursor_x       (cursor_x),
        .cursor_y       (cursor_y)
    );

    // Pack the result
    assign m_axis_tdata = {4'b0000, cursor_y, cursor_x, out_entry.rows,
                           out_entry.data, out_entry.address};
    assign m_axis_tuser = out_entry.op;
    assign m_axis_tlast = status.send_last;

endmodule
`default_nettype wire
